>>> sv/four_level_priority_queue_top_assert.svh
// Assertion macros for the four-level priority queue.
// All checks are sampled on the rising edge of clk and are off while rst_n is low.
`ifndef FOUR_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define FOUR_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpq check failed");

// Consequent must hold in the cycle after the antecedent.
`define FPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpq check failed");

`endif

>>> sv/fpq_pkg.sv
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants for the four-level priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Broadcast to every cell; enq/deq already gated by full/empty.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ins;
    } cell_ctl_t;

endpackage

>>> sv/fpq_cell.sv
// ----------------------------------------------------------------------------
// fpq_cell
// One slot of the sorted shift chain: keeps, shifts in from either side,
// or takes the new entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpq_cell
    import fpq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      occ,
    input  logic      left_keep,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // Slot stays put on enqueue when it holds an entry of equal or higher priority.
    assign keep  = occ && (entry_reg.prio >= ctl.ins.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.deq)
        begin
            entry_next = right_entry;
        end
        else if (ctl.enq && !keep)
        begin
            entry_next = left_keep ? ctl.ins : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> sv/four_level_priority_queue_top.sv
// ----------------------------------------------------------------------------
// four_level_priority_queue_top
// Bounded stable priority queue of tagged entries built as a sorted chain of cells.
// ----------------------------------------------------------------------------
//  Channel   Ports                                        Handshake
//  request   command, entry_id, priority_req              start high, busy low
//  result    status, out_id, out_priority, is_empty       done strobe, one cycle
//
//  One request per cycle; the result shows on done in the cycle after start.
//  busy is held low: every chain cell compares and shifts in the same cycle,
//  so the store is up to date for the next request.
//  Reset clears the fill count and the result strobe; the cells need no reset.
//  The receiver cannot stall; each result is valid for exactly one cycle.
`timescale 1ns / 1ps

module four_level_priority_queue_top
    import fpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              command,
    input  logic [ID_W-1:0]   entry_id,
    input  logic [PRIO_W-1:0] priority_req,
    output logic              done,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   out_id,
    output logic [PRIO_W-1:0] out_priority,
    output logic              is_empty
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;
    logic [PRIO_W-1:0] out_priority_reg;
    logic [PRIO_W-1:0] out_priority_next;
    logic              is_empty_reg;

    cell_ctl_t ctl;
    entry_t    cell_entry [CAPACITY];
    logic      cell_keep  [CAPACITY];
    logic      full;
    logic      empty;

    assign busy  = 1'b0;
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctl.enq      = start && (command == CMD_ENQ) && !full;
    assign ctl.deq      = start && (command == CMD_DEQ) && !empty;
    assign ctl.ins.prio = priority_req;
    assign ctl.ins.id   = entry_id;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   occ;
        logic   lk;
        entry_t le;
        entry_t re;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign lk = 1'b1;
            assign le = ctl.ins;
        end
        else
        begin : g_mid
            assign lk = cell_keep[i-1];
            assign le = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign re = '0;
        end
        else
        begin : g_inner
            assign re = cell_entry[i+1];
        end

        fpq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occ         (occ),
            .left_keep   (lk),
            .left_entry  (le),
            .right_entry (re),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        count_next        = count_reg;
        status_next       = ST_ENQUEUED;
        out_id_next       = '0;
        out_priority_next = '0;
        if (command == CMD_ENQ)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next       = ST_DEQUEUED;
                out_id_next       = cell_entry[0].id;
                out_priority_next = cell_entry[0].prio;
                count_next        = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            done_reg         <= 1'b0;
            status_reg       <= ST_ENQUEUED;
            out_id_reg       <= '0;
            out_priority_reg <= '0;
            is_empty_reg     <= 1'b1;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg        <= count_next;
                status_reg       <= status_next;
                out_id_reg       <= out_id_next;
                out_priority_reg <= out_priority_next;
                is_empty_reg     <= (count_next == '0);
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_priority_reg;
    assign is_empty     = is_empty_reg;

`include "four_level_priority_queue_top_assert.svh"

    `FPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `FPQ_ASSERT_NEXT(a_strobe, start, done)
    `FPQ_ASSERT_NEXT(a_enq_grows, ctl.enq, count_reg == $past(count_reg) + CNT_W'(1))
    `FPQ_ASSERT_NEXT(a_deq_shrinks, ctl.deq, count_reg == $past(count_reg) - CNT_W'(1))
    `FPQ_ASSERT_SAME(a_empty_flag, done && (status == ST_EMPTY), is_empty && (count_reg == '0))

endmodule

>>> dv/four_level_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// four_level_priority_queue_top_tb
// Self-checking bench for the four-level priority queue: a directed table of
// requests, then random bursts that swing the store between empty and full,
// each result checked against a sorted-queue predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_level_priority_queue_top_tb;
    import fpq_pkg::*;

    localparam int IDLE_LIMIT      = 1000;
    localparam int ITEMS_PER_PHASE = 142;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              empty;
    } queue_result_t;

    typedef struct {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        int                reps;
        bit                typed;
        queue_result_t     res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              command;
    logic [ID_W-1:0]   entry_id;
    logic [PRIO_W-1:0] priority_req;
    logic              done;
    logic [1:0]        status;
    logic [ID_W-1:0]   out_id;
    logic [PRIO_W-1:0] out_priority;
    logic              is_empty;

    entry_t        held_entries[$];
    queue_result_t expected_q[$];
    queue_result_t pending_res;
    int            mismatch_cnt = 0;
    int            quiet_cycles = 0;
    int            idle_pct;
    stim_row_t     dir_rows[11];

    four_level_priority_queue_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .entry_id     (entry_id),
        .priority_req (priority_req),
        .done         (done),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .is_empty     (is_empty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sorted insert behind all entries of equal or higher priority; a dequeue pops the head.
    function automatic queue_result_t predict_queue_op(input logic cmd,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [PRIO_W-1:0] prio);
        queue_result_t r;
        entry_t        e;
        int            pos;
        r = '0;
        if (cmd == CMD_ENQ) begin
            if (held_entries.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].prio >= prio)
                    pos++;
                e.prio = prio;
                e.id   = id;
                held_entries.insert(pos, e);
                r.status = ST_ENQUEUED;
            end
        end
        else if (held_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end
        else begin
            e = held_entries.pop_front();
            r.status = ST_DEQUEUED;
            r.id     = e.id;
            r.prio   = e.prio;
        end
        r.empty = (held_entries.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $realtime, name, exp_val, act_val);
            mismatch_cnt++;
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio, input bit typed,
                                input queue_result_t typed_res);
        queue_result_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        predicted    = predict_queue_op(cmd, id, prio);
        pending_res  = typed ? typed_res : predicted;
        command      <= cmd;
        entry_id     <= id;
        priority_req <= prio;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Result check first, then the request taken at this edge.
    always @(posedge clk)
    begin
        queue_result_t exp_res;
        if (rst_n) begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, status %0d id 0x%0h prio %0d empty %0b",
                             $realtime, status, out_id, out_priority, is_empty);
                    mismatch_cnt++;
                end
                else begin
                    exp_res = expected_q.pop_front();
                    check_field("status", exp_res.status, status);
                    check_field("out_id", exp_res.id, out_id);
                    check_field("out_priority", exp_res.prio, out_priority);
                    check_field("is_empty", exp_res.empty, is_empty);
                end
            end
            if (start && !busy)
                expected_q.push_back(pending_res);

            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int     sent;
        int     burst_len;
        int     enq_pct;
        logic   cmd;
        stim_row_t row;

        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_ENQ;
        entry_id     = '0;
        priority_req = '0;
        pending_res  = '0;
        idle_pct     = 0;

        dir_rows = '{
            // dequeue on an empty store, ignored fields set
            '{CMD_DEQ, 16'hFFFF, 2'd3, 1, 1'b1, '{ST_EMPTY, 16'h0000, 2'd0, 1'b1}},
            '{CMD_ENQ, 16'hFFFF, 2'd3, 1, 1'b1, '{ST_ENQUEUED, 16'h0000, 2'd0, 1'b0}},
            '{CMD_ENQ, 16'h0000, 2'd0, 1, 1'b1, '{ST_ENQUEUED, 16'h0000, 2'd0, 1'b0}},
            // same level as the head: must queue behind it
            '{CMD_ENQ, 16'h5A5A, 2'd3, 1, 1'b0, '0},
            '{CMD_ENQ, 16'hA5A5, 2'd1, 1, 1'b0, '0},
            '{CMD_DEQ, 16'h1234, 2'd2, 1, 1'b1, '{ST_DEQUEUED, 16'hFFFF, 2'd3, 1'b0}},
            '{CMD_DEQ, 16'h0000, 2'd0, 1, 1'b0, '0},
            '{CMD_DEQ, 16'h0000, 2'd0, 1, 1'b0, '0},
            '{CMD_DEQ, 16'h0000, 2'd0, 1, 1'b1, '{ST_DEQUEUED, 16'h0000, 2'd0, 1'b1}},
            // fill to capacity with rotating priorities, then one refused request
            '{CMD_ENQ, 16'h0100, 2'd0, CAPACITY, 1'b1, '{ST_ENQUEUED, 16'h0000, 2'd0, 1'b0}},
            '{CMD_ENQ, 16'h7777, 2'd2, 1, 1'b1, '{ST_FULL, 16'h0000, 2'd0, 1'b0}}
        };

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            for (int k = 0; k < row.reps; k++)
                send_request(row.cmd, row.id + ID_W'(k), row.prio + k[1:0], row.typed,
                             row.res);
        end

        for (int phase = 0; phase < 3; phase++) begin
            start <= 1'b0;
            @(negedge clk);
            wait_all_results();
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 83 : 0;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // bursts lean toward filling, draining, or neither
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                burst_len = $urandom_range(8, 40);
                for (int k = 0; k < burst_len && sent < ITEMS_PER_PHASE; k++) begin
                    cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                    send_request(cmd, ID_W'($urandom_range(16'hFFFF, 0)),
                                 PRIO_W'($urandom_range(3, 0)), 1'b0, '0);
                    sent++;
                end
            end
        end

        start <= 1'b0;
        @(negedge clk);
        wait_all_results();
        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
